// ----- sv/assert_macros.svh -----
// assertion helpers used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bpr_pkg.sv -----
package bpr_pkg;

  localparam logic [1:0] KIND_RECT   = 2'd0;
  localparam logic [1:0] KIND_MATRIX = 2'd1;
  localparam logic [1:0] KIND_CX     = 2'd2;
  localparam logic [1:0] KIND_CXA    = 2'd3;

  localparam logic [1:0] ROLE_SKIP   = 2'd0;
  localparam logic [1:0] ROLE_FLAG   = 2'd1;
  localparam logic [1:0] ROLE_PREFIX = 2'd2;
  localparam logic [1:0] ROLE_FIELD  = 2'd3;

  localparam logic [1:0] GATE_NONE = 2'd0;
  localparam logic [1:0] GATE_F0   = 2'd1;
  localparam logic [1:0] GATE_F1   = 2'd2;

  localparam logic [4:0] LONG_PREFIX_BITS  = 5'd5;
  localparam logic [4:0] SHORT_PREFIX_BITS = 5'd4;
  localparam logic [3:0] BYTE_BITS         = 4'd8;
  localparam int         BYTE_MSB          = 7;

  typedef struct packed {
    logic [1:0] role;
    logic [1:0] gate;
    logic [2:0] slot;
    logic       fbit;
    logic       fin;
  } uword_t;

  typedef struct packed {
    logic [2:0] tag;
    logic [2:0] addr;
    logic       last;
  } eword_t;

  typedef struct packed {
    logic       load_byte;
    logic       start;
    logic       shift;
    logic       clr_accum;
    logic       finish;
    logic [1:0] role;
    logic [2:0] slot;
    logic       fbit;
    logic [1:0] kind;
    logic [2:0] rd_addr;
  } ctl_t;

  typedef struct packed {
    logic [1:0] gflags;
    logic [4:0] field_bits;
  } stat_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [2:0] tag;
    logic       last;
  } emit_t;

  function automatic uword_t mk(input logic [1:0] role, input logic [1:0] gate,
                                input logic [2:0] slot, input logic fbit);
    uword_t w;
    w.role = role;
    w.gate = gate;
    w.slot = slot;
    w.fbit = fbit;
    w.fin  = 1'b0;
    return w;
  endfunction

  // control store: one word per (kind, step)
  function automatic uword_t ucode(input logic [1:0] kind, input logic [3:0] ph);
    uword_t w;
    w.role = ROLE_SKIP;
    w.gate = GATE_NONE;
    w.slot = 3'd0;
    w.fbit = 1'b0;
    w.fin  = 1'b1;
    case (kind) inside
      KIND_RECT: begin
        case (ph)
          4'd1: w = mk(ROLE_PREFIX, GATE_NONE, 3'd0, 1'b0);
          4'd2, 4'd3, 4'd4, 4'd5: w = mk(ROLE_FIELD, GATE_NONE, 3'(ph - 4'd2), 1'b0);
          default: ;
        endcase
      end
      KIND_MATRIX: begin
        case (ph)
          4'd1:  w = mk(ROLE_FLAG,   GATE_NONE, 3'd0, 1'b0);
          4'd2:  w = mk(ROLE_PREFIX, GATE_F0,   3'd0, 1'b0);
          4'd3:  w = mk(ROLE_FIELD,  GATE_F0,   3'd0, 1'b0);
          4'd4:  w = mk(ROLE_FIELD,  GATE_F0,   3'd1, 1'b0);
          4'd5:  w = mk(ROLE_FLAG,   GATE_NONE, 3'd0, 1'b1);
          4'd6:  w = mk(ROLE_PREFIX, GATE_F1,   3'd0, 1'b0);
          4'd7:  w = mk(ROLE_FIELD,  GATE_F1,   3'd2, 1'b0);
          4'd8:  w = mk(ROLE_FIELD,  GATE_F1,   3'd3, 1'b0);
          4'd9:  w = mk(ROLE_PREFIX, GATE_NONE, 3'd0, 1'b0);
          4'd10: w = mk(ROLE_FIELD,  GATE_NONE, 3'd4, 1'b0);
          4'd11: w = mk(ROLE_FIELD,  GATE_NONE, 3'd5, 1'b0);
          default: ;
        endcase
      end
      KIND_CX, KIND_CXA: begin
        case (ph)
          4'd1: w = mk(ROLE_FLAG,   GATE_NONE, 3'd0, 1'b0);
          4'd2: w = mk(ROLE_FLAG,   GATE_NONE, 3'd0, 1'b1);
          4'd3: w = mk(ROLE_PREFIX, GATE_NONE, 3'd0, 1'b0);
          4'd4, 4'd5, 4'd6, 4'd7:
            w = mk(ROLE_FIELD, GATE_F1, 3'(ph - 4'd4), 1'b0);
          4'd8, 4'd9, 4'd10, 4'd11:
            w = mk(ROLE_FIELD, GATE_F0, 3'(ph - 4'd4), 1'b0);
          default: ;
        endcase
        // alpha terms only in the alpha variant
        if (kind == KIND_CX && (ph == 4'd7 || ph == 4'd11)) begin
          w.role = ROLE_SKIP;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // result order per kind
  function automatic eword_t erom(input logic [1:0] kind, input logic [2:0] k);
    eword_t e;
    e.tag  = k;
    e.addr = k;
    e.last = (k == 3'd7);
    case (kind) inside
      KIND_RECT: begin
        // y0 sits in slot 2, width in slot 1
        if (k == 3'd1) begin
          e.addr = 3'd2;
        end else if (k == 3'd2) begin
          e.addr = 3'd1;
        end
        e.last = (k == 3'd3);
      end
      KIND_MATRIX: e.last = (k == 3'd5);
      KIND_CX: begin
        e.tag  = (k < 3'd3) ? k : k + 3'd1;
        e.addr = e.tag;
        e.last = (k == 3'd5);
      end
      default: ;
    endcase
    return e;
  endfunction

endpackage

// ----- sv/bpr_dp.sv -----
module bpr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_data_byte,
  input  bpr_pkg::ctl_t       ctl,
  output bpr_pkg::stat_t      stat,
  output logic signed [31:0]  rd_data,
  output logic                rd_present
);

  logic [7:0]  byte_r;
  logic [31:0] accum_r;
  logic [31:0] prev_r;
  logic [1:0]  gflags_r;
  logic [4:0]  field_bits_r;
  logic [7:0]  present_r;
  logic [31:0] store_r [8];
  logic [31:0] rd_data_r;
  logic        rd_pres_r;

  logic [4:0]  fb_m1;
  logic [31:0] sext;
  logic [31:0] wr_val;

  always_comb begin
    fb_m1 = field_bits_r - 5'd1;
    sext  = accum_r;
    if (field_bits_r != 5'd0 && accum_r[fb_m1]) begin
      sext = accum_r | (32'hFFFF_FFFF << field_bits_r);
    end
    // rect extents: x1 - x0 and y1 - y0
    wr_val = (ctl.kind == bpr_pkg::KIND_RECT && ctl.slot[0]) ? sext - prev_r : sext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      gflags_r     <= '0;
      field_bits_r <= '0;
      present_r    <= '0;
    end else if (ctl.start) begin
      accum_r      <= '0;
      gflags_r     <= '0;
      field_bits_r <= '0;
      present_r    <= '0;
    end else begin
      if (ctl.clr_accum) begin
        accum_r <= '0;
      end else if (ctl.shift) begin
        accum_r <= {accum_r[30:0], byte_r[bpr_pkg::BYTE_MSB]};
      end
      if (ctl.finish) begin
        unique case (ctl.role)
          bpr_pkg::ROLE_FLAG:   gflags_r[ctl.fbit] <= gflags_r[ctl.fbit] | accum_r[0];
          bpr_pkg::ROLE_PREFIX: field_bits_r <= accum_r[4:0];
          bpr_pkg::ROLE_FIELD:  present_r[ctl.slot] <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      byte_r <= in_data_byte;
    end else if (ctl.shift) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
    if (ctl.finish && ctl.role == bpr_pkg::ROLE_FIELD) begin
      store_r[ctl.slot] <= wr_val;
      prev_r            <= sext;
    end
    rd_data_r <= store_r[ctl.rd_addr];
    rd_pres_r <= present_r[ctl.rd_addr];
  end

  assign stat.gflags     = gflags_r;
  assign stat.field_bits = field_bits_r;
  assign rd_data         = rd_data_r;
  assign rd_present      = rd_pres_r;

endmodule

// ----- sv/bpr_seq.sv -----
module bpr_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_start_record,
  input  logic [1:0]      in_opcode,
  input  bpr_pkg::stat_t  stat,
  input  logic            out_free,
  output bpr_pkg::ctl_t   ctl,
  output bpr_pkg::emit_t  emit
);

  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ENTER   = 3'd1;
  localparam logic [2:0] S_SHIFT   = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_WR = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [4:0] bits_left_r, bits_left_nxt;
  logic [3:0] bitcnt_r, bitcnt_nxt;
  logic [2:0] emit_k_r, emit_k_nxt;

  bpr_pkg::uword_t uw;
  bpr_pkg::eword_t ew;
  logic            gate_ok;
  logic [1:0]      role_eff;
  logic [4:0]      width;
  logic            acc;

  always_comb begin
    uw      = bpr_pkg::ucode(kind_r, phase_r);
    ew      = bpr_pkg::erom(kind_r, emit_k_r);
    gate_ok = (uw.gate == bpr_pkg::GATE_NONE) ||
              (uw.gate == bpr_pkg::GATE_F0 && stat.gflags[0]) ||
              (uw.gate == bpr_pkg::GATE_F1 && stat.gflags[1]);
    role_eff = gate_ok ? uw.role : bpr_pkg::ROLE_SKIP;
    unique case (role_eff)
      bpr_pkg::ROLE_FLAG:   width = 5'd1;
      bpr_pkg::ROLE_PREFIX: width = kind_r[1] ? bpr_pkg::SHORT_PREFIX_BITS
                                              : bpr_pkg::LONG_PREFIX_BITS;
      bpr_pkg::ROLE_FIELD:  width = stat.field_bits;
      default:              width = 5'd0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    phase_nxt     = phase_r;
    bits_left_nxt = bits_left_r;
    bitcnt_nxt    = bitcnt_r;
    emit_k_nxt    = emit_k_r;

    ctl           = '0;
    ctl.role      = role_eff;
    ctl.slot      = uw.slot;
    ctl.fbit      = uw.fbit;
    ctl.kind      = kind_r;
    ctl.rd_addr   = ew.addr;

    emit.vld      = 1'b0;
    emit.kind     = kind_r;
    emit.tag      = ew.tag;
    emit.last     = ew.last;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          ctl.load_byte = 1'b1;
          bitcnt_nxt    = bpr_pkg::BYTE_BITS;
          if (in_start_record) begin
            // a new record drops any open one
            ctl.start = 1'b1;
            kind_nxt  = in_opcode;
            phase_nxt = 4'd1;
            state_nxt = S_ENTER;
          end else if (phase_r != 4'd0) begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_ENTER: begin
        if (uw.fin) begin
          phase_nxt  = 4'd0;
          emit_k_nxt = 3'd0;
          state_nxt  = S_EMIT_RD;
        end else if (role_eff == bpr_pkg::ROLE_SKIP) begin
          phase_nxt = phase_r + 4'd1;
        end else begin
          ctl.clr_accum = 1'b1;
          bits_left_nxt = width;
          state_nxt     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (bits_left_r == 5'd0) begin
          ctl.finish = 1'b1;
          phase_nxt  = phase_r + 4'd1;
          state_nxt  = S_ENTER;
        end else if (bitcnt_r == 4'd0) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.shift     = 1'b1;
          bitcnt_nxt    = bitcnt_r - 4'd1;
          bits_left_nxt = bits_left_r - 5'd1;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT_WR;
      S_EMIT_WR: begin
        if (out_free) begin
          emit.vld = 1'b1;
          if (ew.last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_k_nxt = emit_k_r + 3'd1;
            state_nxt  = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= bpr_pkg::KIND_RECT;
      phase_r     <= '0;
      bits_left_r <= '0;
      bitcnt_r    <= '0;
      emit_k_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      phase_r     <= phase_nxt;
      bits_left_r <= bits_left_nxt;
      bitcnt_r    <= bitcnt_nxt;
      emit_k_r    <= emit_k_nxt;
    end
  end

  `BPR_ASSERT_NEXT(a_start_enter, clk, rst_n, acc && in_start_record,
                   state_r == S_ENTER && phase_r == 4'd1, "start item did not open a record")
  `BPR_ASSERT_NOW(a_emit_closed, clk, rst_n, emit.vld,
                  phase_r == 4'd0, "result emitted while record still open")
  `BPR_ASSERT_NEXT(a_last_idle, clk, rst_n, emit.vld && emit.last,
                   state_r == S_IDLE, "sequencer not idle after last result")
  `BPR_ASSERT_NOW(a_shift_bits, clk, rst_n, ctl.shift,
                  bitcnt_r != 4'd0 && bits_left_r != 5'd0, "shift without bits")

endmodule

// ----- sv/bitpacked_record_parser.sv -----
// channel | ports                                              | accepted when
// in      | in_data_byte, in_start_record, in_opcode           | in_valid && in_ready
// out     | out_record_kind, out_field_tag, out_field_value,   | out_valid && out_ready
//         | out_present, out_last                              |
//
// a byte is accepted in S_IDLE and its bits (up to 8) are shifted in S_SHIFT, which goes
// back to S_IDLE if they run out mid-record; each step, a start too, passes S_ENTER; a
// finished record emits 4 to 8 results, each a registered store read then an output write
// rst_n is synchronous, active low; a record is open only after a start item
// input stalls while the sequencer parses or emits; the output register lets the
// next byte in while the last result of a record waits for out_ready
module bitpacked_record_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_record,
  input  logic [1:0]         in_opcode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_record_kind,
  output logic [2:0]         out_field_tag,
  output logic signed [31:0] out_field_value,
  output logic               out_present,
  output logic               out_last
);

  bpr_pkg::ctl_t     ctl;
  bpr_pkg::stat_t    stat;
  bpr_pkg::emit_t    emit;
  logic signed [31:0] rd_data;
  logic               rd_present;
  logic               out_free;

  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic [2:0]         tag_r;
  logic signed [31:0] value_r;
  logic               present_r;
  logic               last_r;

  assign out_free = !out_valid_r || out_ready;

  bpr_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_record (in_start_record),
    .in_opcode       (in_opcode),
    .stat            (stat),
    .out_free        (out_free),
    .ctl             (ctl),
    .emit            (emit)
  );

  bpr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .ctl          (ctl),
    .stat         (stat),
    .rd_data      (rd_data),
    .rd_present   (rd_present)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      kind_r    <= emit.kind;
      tag_r     <= emit.tag;
      value_r   <= rd_present ? rd_data : 32'sd0;
      present_r <= rd_present;
      last_r    <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = kind_r;
  assign out_field_tag   = tag_r;
  assign out_field_value = value_r;
  assign out_present     = present_r;
  assign out_last        = last_r;

endmodule
